/* hw/rtl/wpq_pkg.sv */
// ----------------------------------------------------------------------------
// Weighted priority queue package
// Shared entry type, status and register codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package wpq_pkg;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] prio;
        logic [31:0] tick;
    } t_entry;

    localparam logic [2:0] ST_QUEUED   = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_DEQUEUED = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [2:0] CFG_W_SEV   = 3'd0;
    localparam logic [2:0] CFG_W_INF   = 3'd1;
    localparam logic [2:0] CFG_W_DIST  = 3'd2;
    localparam logic [2:0] CFG_W_TIME  = 3'd3;
    localparam logic [2:0] CFG_D_RECIP = 3'd4;
    localparam logic [2:0] CFG_T_RECIP = 3'd5;

    localparam logic [15:0] RST_W_SEV   = 16'd26214;
    localparam logic [15:0] RST_W_INF   = 16'd19661;
    localparam logic [15:0] RST_W_DIST  = 16'd9830;
    localparam logic [15:0] RST_W_TIME  = 16'd9830;
    localparam logic [15:0] RST_D_RECIP = 16'd1311;
    localparam logic [15:0] RST_T_RECIP = 16'd1165;

    localparam logic [2:0] CALC_LAST = 3'd5;
    localparam logic [4:0] DIV_LAST  = 5'd31;

    typedef struct packed {
        logic       load_in;
        logic       calc;
        logic       decide;
        logic       ins_new;
        logic       ins_step;
        logic       pool_wr;
        logic       deq_pop;
        logic       div_step;
        logic       promote;
        logic       out_load;
        logic [4:0] step;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic count_full;
        logic count_zero;
        logic spill_full;
        logic spill_zero;
        logic ins_done;
    } t_stat;

endpackage

/* hw/rtl/wpq_dp.sv */
// ----------------------------------------------------------------------------
// Weighted priority queue datapath
// Priority arithmetic, sorted queue, overflow pool, modulo unit and outputs.
// ----------------------------------------------------------------------------
module wpq_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int POOL_DEPTH  = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_func,
    input  logic [15:0]   i_requester_id,
    input  logic [15:0]   i_severity,
    input  logic [15:0]   i_influence,
    input  logic [15:0]   i_distance,
    input  logic [31:0]   i_arrival_tick,
    input  logic [15:0]   i_idle_ticks,
    input  wpq_pkg::t_cmd i_cmd,
    output wpq_pkg::t_stat o_stat,
    output logic [2:0]    o_status,
    output logic [15:0]   o_out_id,
    output logic [15:0]   o_out_priority,
    output logic [31:0]   o_out_tick,
    output logic [4:0]    o_queue_count,
    output logic [2:0]    o_pool_count
);
    import wpq_pkg::*;

    localparam int QIW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int PIW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int PCW = $clog2(POOL_DEPTH + 1);

    logic [15:0] r_w_sev, r_w_inf, r_w_dist, r_w_time, r_d_recip, r_t_recip;
    logic        r_func;
    logic [15:0] r_id, r_sev, r_inf, r_dist, r_idle;
    logic [31:0] r_tick;
    logic [16:0] r_near, r_tn;
    logic [34:0] r_acc;
    t_entry      r_q [QUEUE_DEPTH];
    t_entry      r_pool [POOL_DEPTH];
    logic [QCW-1:0] r_count;
    logic [PCW-1:0] r_spill;
    logic [31:0] r_total;
    logic [QIW-1:0] r_i;
    t_entry      r_ins;
    logic [31:0] r_dvd;
    logic [PCW-1:0] r_rem;
    logic [15:0] r_w_id, r_w_prio;
    logic [31:0] r_w_tick;
    logic [2:0]  r_o_status;
    logic [15:0] r_o_id, r_o_prio;
    logic [31:0] r_o_tick;
    logic [4:0]  r_o_qc;
    logic [2:0]  r_o_pc;

    logic [15:0] mul_a;
    logic [16:0] mul_b;
    logic [32:0] prod;
    logic [23:0] scaled;
    logic [16:0] near;
    logic [16:0] tn;
    logic [15:0] prio;
    t_entry      new_e;
    t_entry      prev_e;
    logic        goes_before;
    logic [PCW:0]   div_tmp;
    logic [PIW-1:0] k;
    logic [QIW-1:0] i_prev;

    always_comb begin
        case (i_cmd.step[2:0])
            3'd0: begin
                mul_a = r_dist;
                mul_b = {1'b0, r_d_recip};
            end
            3'd1: begin
                mul_a = r_idle;
                mul_b = {1'b0, r_t_recip};
            end
            3'd2: begin
                mul_a = r_w_sev;
                mul_b = {1'b0, r_sev};
            end
            3'd3: begin
                mul_a = r_w_inf;
                mul_b = {1'b0, r_inf};
            end
            3'd4: begin
                mul_a = r_w_dist;
                mul_b = r_near;
            end
            3'd5: begin
                mul_a = r_w_time;
                mul_b = r_tn;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = 33'(mul_a) * 33'(mul_b);
    assign scaled = prod[31:8];
    assign near   = (scaled[23:16] != 8'd0) ? 17'd0 : (17'h10000 - {1'b0, scaled[15:0]});
    assign tn     = (prod[32:8] > 25'h10000) ? 17'h10000 : prod[24:8];
    assign prio   = (r_acc[34:32] != 3'd0) ? 16'hFFFF : r_acc[31:16];

    assign new_e  = '{id: r_id, prio: prio, tick: r_tick};
    assign i_prev = r_i - QIW'(1);
    assign prev_e = r_q[i_prev];
    assign goes_before = (r_ins.prio[15:6] > prev_e.prio[15:6]) ||
                         ((r_ins.prio[15:6] == prev_e.prio[15:6]) &&
                          (r_ins.tick < prev_e.tick));

    assign div_tmp = {r_rem, r_dvd[31]};
    assign k       = r_rem[PIW-1:0];

    assign o_stat.func       = r_func;
    assign o_stat.count_full = (r_count == QCW'(QUEUE_DEPTH));
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.spill_full = (r_spill == PCW'(POOL_DEPTH));
    assign o_stat.spill_zero = (r_spill == '0);
    assign o_stat.ins_done   = (r_i == '0) || !goes_before;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_sev   <= RST_W_SEV;
            r_w_inf   <= RST_W_INF;
            r_w_dist  <= RST_W_DIST;
            r_w_time  <= RST_W_TIME;
            r_d_recip <= RST_D_RECIP;
            r_t_recip <= RST_T_RECIP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_W_SEV:   r_w_sev   <= i_cfg_data;
                CFG_W_INF:   r_w_inf   <= i_cfg_data;
                CFG_W_DIST:  r_w_dist  <= i_cfg_data;
                CFG_W_TIME:  r_w_time  <= i_cfg_data;
                CFG_D_RECIP: r_d_recip <= i_cfg_data;
                CFG_T_RECIP: r_t_recip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_spill <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.ins_step && o_stat.ins_done) begin
                r_count <= r_count + QCW'(1);
            end
            if (i_cmd.deq_pop) begin
                r_count <= r_count - QCW'(1);
                r_total <= r_total + 32'd1;
            end
            if (i_cmd.pool_wr) begin
                r_spill <= r_spill + PCW'(1);
            end
            if (i_cmd.promote) begin
                r_spill <= r_spill - PCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func   <= i_func;
            r_id     <= i_requester_id;
            r_sev    <= i_severity;
            r_inf    <= i_influence;
            r_dist   <= i_distance;
            r_tick   <= i_arrival_tick;
            r_idle   <= i_idle_ticks;
            r_w_id   <= '0;
            r_w_prio <= '0;
            r_w_tick <= '0;
        end
        if (i_cmd.calc) begin
            case (i_cmd.step[2:0])
                3'd0:    r_near <= near;
                3'd1:    r_tn   <= tn;
                3'd2:    r_acc  <= 35'(prod);
                default: r_acc  <= r_acc + 35'(prod);
            endcase
        end
        if (i_cmd.decide) begin
            r_w_prio <= prio;
        end
        if (i_cmd.ins_new) begin
            r_ins <= new_e;
            r_i   <= r_count[QIW-1:0];
        end
        if (i_cmd.promote) begin
            r_ins <= r_pool[k];
            r_i   <= r_count[QIW-1:0];
        end
        if (i_cmd.ins_step) begin
            if (o_stat.ins_done) begin
                r_q[r_i] <= r_ins;
            end else begin
                r_q[r_i] <= prev_e;
                r_i      <= i_prev;
            end
        end
        if (i_cmd.deq_pop) begin
            r_w_id   <= r_q[0].id;
            r_w_prio <= r_q[0].prio;
            r_w_tick <= r_q[0].tick;
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                r_q[j] <= r_q[j + 1];
            end
            r_dvd <= r_total + 32'd1;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            if (div_tmp >= {1'b0, r_spill}) begin
                r_rem <= PCW'(div_tmp - {1'b0, r_spill});
            end else begin
                r_rem <= div_tmp[PCW-1:0];
            end
        end
        if (i_cmd.pool_wr) begin
            r_pool[r_spill[PIW-1:0]] <= new_e;
        end
        if (i_cmd.promote) begin
            for (int j = 0; j < POOL_DEPTH - 1; j++) begin
                if (PIW'(j) >= k) begin
                    r_pool[j] <= r_pool[j + 1];
                end
            end
        end
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.status;
            r_o_id     <= r_w_id;
            r_o_prio   <= r_w_prio;
            r_o_tick   <= r_w_tick;
            r_o_qc     <= 5'(r_count);
            r_o_pc     <= 3'(r_spill);
        end
    end

    assign o_status       = r_o_status;
    assign o_out_id       = r_o_id;
    assign o_out_priority = r_o_prio;
    assign o_out_tick     = r_o_tick;
    assign o_queue_count  = r_o_qc;
    assign o_pool_count   = r_o_pc;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QUEUE_DEPTH))
        else $error("Queue count exceeds depth.");

    a_spill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spill <= PCW'(POOL_DEPTH))
        else $error("Pool count exceeds depth.");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.deq_pop |=> r_count == $past(r_count) - QCW'(1))
        else $error("Pop did not remove exactly one entry.");

endmodule

/* hw/rtl/wpq_ctrl.sv */
// ----------------------------------------------------------------------------
// Weighted priority queue controller
// Sequences priority steps, insertion, pop, modulo and promotion per word.
// ----------------------------------------------------------------------------
module wpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  wpq_pkg::t_stat i_stat,
    output wpq_pkg::t_cmd  o_cmd
);
    import wpq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CALC   = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_INS    = 8'b0000_1000,
        S_DEQ    = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_PROM   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic [2:0] r_status, n_status;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_step        = '0;
                    n_state       = S_DEQ;
                end
            end
            S_DEQ: begin
                if (!i_stat.func) begin
                    n_state = S_CALC;
                end else if (i_stat.count_zero) begin
                    n_status = ST_EMPTY;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.deq_pop = 1'b1;
                    n_status      = ST_DEQUEUED;
                    n_state       = i_stat.spill_zero ? S_DONE : S_DIV;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_step     = r_step + 5'd1;
                if (r_step[2:0] == CALC_LAST) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (!i_stat.count_full) begin
                    o_cmd.ins_new = 1'b1;
                    n_status      = ST_QUEUED;
                    n_state       = S_INS;
                end else if (!i_stat.spill_full) begin
                    o_cmd.pool_wr = 1'b1;
                    n_status      = ST_OVERFLOW;
                    n_state       = S_DONE;
                end else begin
                    n_status = ST_REJECTED;
                    n_state  = S_DONE;
                end
            end
            S_INS: begin
                o_cmd.ins_step = 1'b1;
                if (i_stat.ins_done) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 5'd1;
                if (r_step == DIV_LAST) begin
                    n_state = S_PROM;
                end
            end
            S_PROM: begin
                o_cmd.promote = 1'b1;
                n_state       = S_INS;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_status    <= ST_QUEUED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("Result loaded over an unread word.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Controller did not leave idle after accepting a word.");

endmodule

/* hw/rtl/weighted_priority_queue_with_overflow_top.sv */
// ----------------------------------------------------------------------------
// Weighted priority queue with overflow pool
// Channel   Direction  Handshake                  Contents
// input     in         i_in_valid / o_in_ready    request word (func and fields)
// output    out        o_out_valid / i_out_ready  result word (status and fields)
// config    in         i_cfg_we                   weights and reciprocals
//
// An enqueue that overflows or is rejected passes a dispatch state, six steps of one
// shared multiplier and a decision state; a queued one then makes one sorted-queue
// shift per cycle until its slot is found. A dequeue pops the head and, if the pool
// is not empty, runs the 32-step modulo and reinserts the promoted entry.
// Reset is synchronous and active low and clears counts and the controller.
// A held output word stalls the final handoff, and no new word is taken meanwhile.
// ----------------------------------------------------------------------------
module weighted_priority_queue_with_overflow_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int POOL_DEPTH  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [15:0] i_requester_id,
    input  logic [15:0] i_severity,
    input  logic [15:0] i_influence,
    input  logic [15:0] i_distance,
    input  logic [31:0] i_arrival_tick,
    input  logic [15:0] i_idle_ticks,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_id,
    output logic [15:0] o_out_priority,
    output logic [31:0] o_out_tick,
    output logic [4:0]  o_queue_count,
    output logic [2:0]  o_pool_count
);
    import wpq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    wpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    wpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .POOL_DEPTH  (POOL_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_requester_id (i_requester_id),
        .i_severity     (i_severity),
        .i_influence    (i_influence),
        .i_distance     (i_distance),
        .i_arrival_tick (i_arrival_tick),
        .i_idle_ticks   (i_idle_ticks),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_out_tick     (o_out_tick),
        .o_queue_count  (o_queue_count),
        .o_pool_count   (o_pool_count)
    );

endmodule
